/* design/pspm_pkg.sv */
// Package for the serial port master: frame phase codes, request codes and
// fixed register defaults. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pspm_pkg;

  // Request codes on req_type
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Frame phase codes
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_BEGIN    = 4'd1;
  localparam logic [3:0] PH_RW_LO    = 4'd2;
  localparam logic [3:0] PH_RW_HI    = 4'd3;
  localparam logic [3:0] PH_ADDR_LO  = 4'd4;
  localparam logic [3:0] PH_ADDR_HI  = 4'd5;
  localparam logic [3:0] PH_DATA_LO  = 4'd6;
  localparam logic [3:0] PH_DATA_HI  = 4'd7;
  localparam logic [3:0] PH_GAP_LO   = 4'd8;
  localparam logic [3:0] PH_GAP_HI   = 4'd9;
  localparam logic [3:0] PH_RD_LO    = 4'd10;
  localparam logic [3:0] PH_RD_HI    = 4'd11;
  localparam logic [3:0] PH_CLOSE_LO = 4'd12;
  localparam logic [3:0] PH_SEN_LO   = 4'd13;

  localparam logic [7:0] HALF_PERIOD_RESET = 8'd4;

  // Pin levels and frame status after a tick
  typedef struct packed {
    logic sck;
    logic sen;
    logic sdi;
    logic busy;
    logic done;
  } status_t;

endpackage

`default_nettype wire

/* design/pll_serial_port_master.sv */
// Top level of the serial port master: input register, handshakes,
// half period register and result valid. Depends on pspm_pkg, pspm_engine.
//
//   channel  direction  handshake              payload
//   in       into block in_valid / in_stall    req_type, reg_address,
//                                              write_data, sdo_in
//   out      from block out_valid / out_stall  sck_out, sen_out, sdi_out,
//                                              busy_res, done_res, read_result
//   cfg      into block cfg_valid / cfg_ready  cfg_data (half_period_ticks)
//
// Each transaction on in is one tick of the serial engine and gives exactly
// one transaction on out. It passes through the input register and then
// through the engine into its state and result registers; one tick is
// taken every cycle while out is not stalled. Reset is synchronous and
// puts the engine idle with all pins low, the read word at zero and the
// half period at four ticks. A stall on out holds the result and the engine;
// in stalls in that same cycle when the input register is full, and an empty
// input register still takes one more transaction first.
`timescale 1ns / 1ps
`default_nettype none

module pll_serial_port_master #(
  parameter int ADDR_BITS      = 6,
  parameter int DATA_BITS      = 24,
  parameter int LONG_GAP_UNITS = 5
) (
  input  wire                  clk,
  input  wire                  rst,
  // tick transactions in
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire [1:0]            req_type,
  input  wire [ADDR_BITS-1:0]  reg_address,
  input  wire [DATA_BITS-1:0]  write_data,
  input  wire                  sdo_in,
  // result transactions out
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic                 sck_out,
  output logic                 sen_out,
  output logic                 sdi_out,
  output logic                 busy_res,
  output logic                 done_res,
  output logic [DATA_BITS-1:0] read_result,
  // half period register write
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [7:0]            cfg_data
);
  import pspm_pkg::*;

  // input register
  logic                 in_reg_valid;
  logic [1:0]           in_req;
  logic [ADDR_BITS-1:0] in_addr;
  logic [DATA_BITS-1:0] in_data;
  logic                 in_sdo;

  logic [7:0] half_period_ticks;
  logic       out_free;
  logic       step;
  status_t    status;

  // out can take a new result when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;
  assign step     = in_reg_valid && out_free;
  // stall only when the input register is full and cannot move on
  assign in_stall = in_reg_valid && !out_free;

  // configuration is to be written only while idle; the block does not enforce this, so take it at once
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      half_period_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  // payload holds no reset; load on every accepted transaction
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_req  <= req_type;
      in_addr <= reg_address;
      in_data <= write_data;
      in_sdo  <= sdo_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step;
    end
  end

  pspm_engine #(
    .ADDR_BITS      (ADDR_BITS),
    .DATA_BITS      (DATA_BITS),
    .LONG_GAP_UNITS (LONG_GAP_UNITS)
  ) u_engine (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .half_period_ticks (half_period_ticks),
    .req_type          (in_req),
    .reg_address       (in_addr),
    .write_data        (in_data),
    .sdo_in            (in_sdo),
    .status            (status),
    .read_result       (read_result)
  );

  // engine registers change only on a step, so they hold while out stalls
  assign sck_out  = status.sck;
  assign sen_out  = status.sen;
  assign sdi_out  = status.sdi;
  assign busy_res = status.busy;
  assign done_res = status.done;

endmodule

`default_nettype wire

/* design/pspm_engine.sv */
// Frame engine: phase sequencer, bit/tick/gap counters and shift registers.
// Advances one tick per step. Depends on pspm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pspm_engine #(
  parameter int ADDR_BITS      = 6,
  parameter int DATA_BITS      = 24,
  parameter int LONG_GAP_UNITS = 5
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   step,
  input  wire [7:0]             half_period_ticks,
  input  wire [1:0]             req_type,
  input  wire [ADDR_BITS-1:0]   reg_address,
  input  wire [DATA_BITS-1:0]   write_data,
  input  wire                   sdo_in,
  output pspm_pkg::status_t     status,
  output logic [DATA_BITS-1:0]  read_result
);
  import pspm_pkg::*;

  localparam int SHIFT_W = ADDR_BITS + DATA_BITS;
  localparam int BC_W    = $clog2(DATA_BITS + 1);
  localparam int GC_W    = $clog2(LONG_GAP_UNITS + 1);
  localparam logic [BC_W-1:0] ADDR_LAST = BC_W'(ADDR_BITS);
  localparam logic [BC_W-1:0] DATA_LAST = BC_W'(DATA_BITS);
  localparam logic [GC_W-1:0] GAP_LAST  = GC_W'(LONG_GAP_UNITS);

  logic [3:0]           phase, phase_next;
  logic [BC_W-1:0]      bit_counter, bit_counter_next;
  logic [7:0]           tick_counter, tick_counter_next;
  logic [GC_W-1:0]      gap_counter, gap_counter_next;
  logic [SHIFT_W-1:0]   shift_out, shift_out_next;
  logic [DATA_BITS-1:0] shift_in, shift_in_next;
  logic                 read_frame, read_frame_next;
  logic                 sck, sck_next;
  logic                 sen, sen_next;
  logic                 sdi, sdi_next;
  logic                 done, done_next;
  logic [DATA_BITS-1:0] read_hold, read_hold_next;

  logic                 enter_en;
  logic [3:0]           enter_ph;
  logic [BC_W-1:0]      bit_inc;

  assign bit_inc = bit_counter + 1'b1;

  always_comb begin
    phase_next        = phase;
    bit_counter_next  = bit_counter;
    tick_counter_next = tick_counter;
    gap_counter_next  = gap_counter;
    shift_out_next    = shift_out;
    shift_in_next     = shift_in;
    read_frame_next   = read_frame;
    sck_next          = sck;
    sen_next          = sen;
    sdi_next          = sdi;
    read_hold_next    = read_hold;
    done_next         = 1'b0;
    enter_en          = 1'b0;
    enter_ph          = phase;

    if (phase == PH_IDLE) begin
      // start a frame; ignore anything but a write or read request
      if (req_type == REQ_WRITE || req_type == REQ_READ) begin
        read_frame_next  = (req_type == REQ_READ);
        shift_out_next   = {reg_address, write_data};
        bit_counter_next = '0;
        gap_counter_next = '0;
        enter_en         = 1'b1;
        enter_ph         = PH_BEGIN;
      end
    end else if (tick_counter >= half_period_ticks) begin
      // unit spent: advance the sequence
      case (phase)
        PH_BEGIN: begin
          enter_en = 1'b1;
          enter_ph = PH_RW_LO;
        end
        PH_RW_LO: begin
          enter_en = 1'b1;
          enter_ph = PH_RW_HI;
        end
        PH_RW_HI: begin
          bit_counter_next = '0;
          enter_en         = 1'b1;
          enter_ph         = PH_ADDR_LO;
        end
        PH_ADDR_LO: begin
          enter_en = 1'b1;
          enter_ph = PH_ADDR_HI;
        end
        PH_ADDR_HI: begin
          enter_en = 1'b1;
          if (bit_inc < ADDR_LAST) begin
            bit_counter_next = bit_inc;
            enter_ph         = PH_ADDR_LO;
          end else if (read_frame) begin
            bit_counter_next = bit_inc;
            enter_ph         = PH_GAP_LO;
          end else begin
            bit_counter_next = '0;
            enter_ph         = PH_DATA_LO;
          end
        end
        PH_DATA_LO: begin
          enter_en = 1'b1;
          enter_ph = PH_DATA_HI;
        end
        PH_DATA_HI: begin
          bit_counter_next = bit_inc;
          enter_en         = 1'b1;
          enter_ph         = (bit_inc < DATA_LAST) ? PH_DATA_LO : PH_GAP_LO;
        end
        PH_GAP_LO: begin
          if (gap_counter < GAP_LAST) begin
            gap_counter_next  = gap_counter + 1'b1;
            tick_counter_next = 8'd1;
          end else begin
            enter_en = 1'b1;
            enter_ph = PH_GAP_HI;
          end
        end
        PH_GAP_HI: begin
          enter_en = 1'b1;
          if (read_frame) begin
            bit_counter_next = '0;
            enter_ph         = PH_RD_LO;
          end else begin
            enter_ph = PH_CLOSE_LO;
          end
        end
        PH_RD_LO: begin
          enter_en = 1'b1;
          enter_ph = PH_RD_HI;
        end
        PH_RD_HI: begin
          bit_counter_next = bit_inc;
          enter_en         = 1'b1;
          enter_ph         = (bit_inc < DATA_LAST) ? PH_RD_LO : PH_CLOSE_LO;
        end
        PH_CLOSE_LO: begin
          enter_en = 1'b1;
          enter_ph = PH_SEN_LO;
        end
        default: begin
          // end of frame: publish the captured word on reads
          phase_next        = PH_IDLE;
          tick_counter_next = 8'd0;
          done_next         = 1'b1;
          if (read_frame) begin
            read_hold_next = shift_in;
          end
        end
      endcase
    end else begin
      tick_counter_next = tick_counter + 8'd1;
    end

    // entry actions of the new phase
    if (enter_en) begin
      phase_next        = enter_ph;
      tick_counter_next = 8'd1;
      case (enter_ph)
        PH_BEGIN: begin
          sck_next = 1'b0;
          sen_next = 1'b0;
          sdi_next = 1'b0;
        end
        PH_RW_LO: begin
          sck_next = 1'b0;
          sen_next = 1'b1;
          sdi_next = read_frame;
        end
        PH_ADDR_LO, PH_DATA_LO: begin
          sck_next       = 1'b0;
          sdi_next       = shift_out[SHIFT_W-1];
          shift_out_next = {shift_out[SHIFT_W-2:0], 1'b0};
        end
        PH_GAP_LO: begin
          sck_next         = 1'b0;
          gap_counter_next = GC_W'(1);
        end
        PH_RD_LO: begin
          sck_next      = 1'b0;
          shift_in_next = {shift_in[DATA_BITS-2:0], sdo_in};
        end
        PH_CLOSE_LO: begin
          sck_next = 1'b0;
        end
        PH_SEN_LO: begin
          sen_next = 1'b0;
        end
        default: begin
          sck_next = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_counter  <= '0;
      tick_counter <= '0;
      gap_counter  <= '0;
      shift_out    <= '0;
      shift_in     <= '0;
      read_frame   <= 1'b0;
      sck          <= 1'b0;
      sen          <= 1'b0;
      sdi          <= 1'b0;
      done         <= 1'b0;
      read_hold    <= '0;
    end else if (step) begin
      phase        <= phase_next;
      bit_counter  <= bit_counter_next;
      tick_counter <= tick_counter_next;
      gap_counter  <= gap_counter_next;
      shift_out    <= shift_out_next;
      shift_in     <= shift_in_next;
      read_frame   <= read_frame_next;
      sck          <= sck_next;
      sen          <= sen_next;
      sdi          <= sdi_next;
      done         <= done_next;
      read_hold    <= read_hold_next;
    end
  end

  assign status.sck  = sck;
  assign status.sen  = sen;
  assign status.sdi  = sdi;
  assign status.busy = (phase != PH_IDLE);
  assign status.done = done;
  assign read_result = read_hold;

endmodule

`default_nettype wire
